/* design/npib_pkg.sv */
// Shared types and constants for the nearest in-box point finder.
`default_nettype none

package npib_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 2'd0,
    CFG_BOX_MAX_X = 2'd1,
    CFG_BOX_MIN_Y = 2'd2,
    CFG_BOX_MAX_Y = 2'd3
  } cfg_idx_e;

  // Box bounds after reset, millimeters
  localparam int BOX_MIN_X_RST = -550;
  localparam int BOX_MAX_X_RST = 1200;
  localparam int BOX_MIN_Y_RST = -550;
  localparam int BOX_MAX_Y_RST = 550;

  // Per-stage control that travels with a point through the pipeline
  typedef struct packed {
    logic valid;  // stage holds a point
    logic ok;     // point counts (valid flag, later also inside the box)
    logic last;   // final point of the cloud
  } pt_ctl_t;

endpackage

`default_nettype wire

/* design/npib_dist.sv */
// Box test and squared distance: two pipeline stages with stall propagation.
`default_nettype none

module npib_dist #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  npib_pkg::pt_ctl_t              in_ctl_i,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_i,
  output logic                           in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_y_i,
  output npib_pkg::pt_ctl_t              out_ctl_o,
  output logic signed [COORD_WIDTH-1:0]  out_x_o,
  output logic signed [COORD_WIDTH-1:0]  out_y_o,
  output logic [2*COORD_WIDTH:0]         out_dist_o,
  input  wire                            out_ready_i
);
  import npib_pkg::*;

  localparam int SQ_W = 2 * COORD_WIDTH;
  localparam int D_W  = 2 * COORD_WIDTH + 1;

  pt_ctl_t                        ctl1_q, ctl1_d, ctl2_q;
  logic signed [COORD_WIDTH-1:0]  x1_q, y1_q, x2_q, y2_q;
  logic [SQ_W-1:0]                sqx_q, sqy_q, sqx_d, sqy_d;
  logic [D_W-1:0]                 dist_q;
  logic [COORD_WIDTH-1:0]         xu, yu, ax, ay;
  logic                           in_box;
  logic                           rdy1, rdy2;

  // Stall chain: a stage moves when it is empty or its successor moves
  assign rdy2       = !ctl2_q.valid || out_ready_i;
  assign rdy1       = !ctl1_q.valid || rdy2;
  assign in_ready_o = rdy1;

  // Inclusive box test and magnitudes (most negative value maps to 2^(W-1))
  always_comb begin
    in_box = in_ctl_i.ok &&
             (in_x_i >= box_min_x_i) && (in_x_i <= box_max_x_i) &&
             (in_y_i >= box_min_y_i) && (in_y_i <= box_max_y_i);
    xu     = in_x_i;
    yu     = in_y_i;
    ax     = xu[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - xu) : xu;
    ay     = yu[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - yu) : yu;
    sqx_d  = SQ_W'(ax) * SQ_W'(ax);
    sqy_d  = SQ_W'(ay) * SQ_W'(ay);
    ctl1_d = in_ctl_i;
    ctl1_d.ok = in_box;
  end

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      if (rdy1) ctl1_q <= ctl1_d;
      if (rdy2) ctl2_q <= ctl1_q;
    end
  end

  // Stage payload: squares, then their sum
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      x1_q  <= in_x_i;
      y1_q  <= in_y_i;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
    end
    if (rdy2) begin
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      dist_q <= D_W'(sqx_q) + D_W'(sqy_q);
    end
  end

  assign out_ctl_o  = ctl2_q;
  assign out_x_o    = x2_q;
  assign out_y_o    = y2_q;
  assign out_dist_o = dist_q;

endmodule

`default_nettype wire

/* design/npib_best.sv */
// Running minimum over one cloud and the result register.
`default_nettype none

module npib_best #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  npib_pkg::pt_ctl_t              in_ctl_i,
  input  wire logic signed [COORD_WIDTH-1:0] in_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] in_y_i,
  input  wire logic [2*COORD_WIDTH:0]    in_dist_i,
  output logic                           in_ready_o,
  output logic                           res_valid_o,
  input  wire                            res_ready_i,
  output logic signed [COORD_WIDTH-1:0]  res_lateral_o,
  output logic signed [COORD_WIDTH-1:0]  res_forward_o
);
  import npib_pkg::*;

  localparam int D_W = 2 * COORD_WIDTH + 1;

  logic                          found_q, found_d;
  logic [D_W-1:0]                best_q, best_d;
  logic signed [COORD_WIDTH-1:0] bx_q, bx_d, by_q, by_d;
  logic                          out_v_q, out_v_d;
  logic signed [COORD_WIDTH-1:0] lat_q, lat_d, fwd_q, fwd_d;
  logic                          take, better;

  // Only a last point needs room in the result register
  assign in_ready_o = !in_ctl_i.last || !out_v_q || res_ready_i;
  assign take       = in_ctl_i.valid && in_ready_o;
  // Strictly smaller replaces, so the first of equal points stays
  assign better     = in_ctl_i.ok && (!found_q || (in_dist_i < best_q));

  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    bx_d    = bx_q;
    by_d    = by_q;
    out_v_d = out_v_q && !res_ready_i;
    lat_d   = lat_q;
    fwd_d   = fwd_q;
    if (take) begin
      if (better) begin
        found_d = 1'b1;
        best_d  = in_dist_i;
        bx_d    = in_x_i;
        by_d    = in_y_i;
      end
      if (in_ctl_i.last) begin
        // End of cloud: publish the kept point (coordinates swapped), clear
        if (found_d) begin
          out_v_d = 1'b1;
          lat_d   = by_d;
          fwd_d   = bx_d;
        end
        found_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      found_q <= found_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
    lat_q  <= lat_d;
    fwd_q  <= fwd_d;
  end

  assign res_valid_o   = out_v_q;
  assign res_lateral_o = lat_q;
  assign res_forward_o = fwd_q;

endmodule

`default_nettype wire

/* design/nearest_point_in_box.sv */
// Top level: nearest point of a streamed cloud inside a configurable box.
//
//   channel   dir  payload                                        beats
//   s_axis    in   tdata {y, x}, tuser point_valid, tlast end      one per point
//   m_axis    out  tdata {forward, lateral}                        one per cloud, if found
//   cfg       in   we, addr (box_min_x..box_max_y), wdata          one per write
//
// One point is taken per cycle while the pipeline is not stalled; the path is
// input register, box test and squares, sum, running compare, result register.
// The last point of a cloud passes these registers in order before the result is valid.
// Reset clears the pipeline, the kept point and the result; bounds go to
// -550, 1200, -550, 550 mm.
// A waiting result stalls the pipeline only once a further last point reaches
// the compare stage; other points keep flowing.
`default_nettype none

module nearest_point_in_box #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  // Points in
  input  wire                                       s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  input  wire [((2*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata_i,  // point_x, point_y
  input  wire                                       s_axis_tuser_i,  // point_valid
  input  wire                                       s_axis_tlast_i,
  // Nearest point out
  output logic                                      m_axis_tvalid_o,
  input  wire                                       m_axis_tready_i,
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]        m_axis_tdata_o,  // lateral, forward
  // Configuration writes
  input  wire                                       cfg_we_i,
  input  wire [npib_pkg::CFG_IDX_W-1:0]             cfg_addr_i,
  input  wire [COORD_WIDTH-1:0]                     cfg_wdata_i
);
  import npib_pkg::*;

  localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam logic signed [COORD_WIDTH-1:0] MIN_X_RST = COORD_WIDTH'(BOX_MIN_X_RST);
  localparam logic signed [COORD_WIDTH-1:0] MAX_X_RST = COORD_WIDTH'(BOX_MAX_X_RST);
  localparam logic signed [COORD_WIDTH-1:0] MIN_Y_RST = COORD_WIDTH'(BOX_MIN_Y_RST);
  localparam logic signed [COORD_WIDTH-1:0] MAX_Y_RST = COORD_WIDTH'(BOX_MAX_Y_RST);

  logic signed [COORD_WIDTH-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  pt_ctl_t                       ctl0_q, ctl0_d, dist_ctl;
  logic signed [COORD_WIDTH-1:0] x0_q, y0_q, dist_x, dist_y;
  logic [2*COORD_WIDTH:0]        dist_d;
  logic                          dist_ready, best_ready;
  logic signed [COORD_WIDTH-1:0] res_lat, res_fwd;

  // Box bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= MIN_X_RST;
      max_x_q <= MAX_X_RST;
      min_y_q <= MIN_Y_RST;
      max_y_q <= MAX_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_BOX_MIN_X: min_x_q <= cfg_wdata_i;
        CFG_BOX_MAX_X: max_x_q <= cfg_wdata_i;
        CFG_BOX_MIN_Y: min_y_q <= cfg_wdata_i;
        CFG_BOX_MAX_Y: max_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  assign s_axis_tready_o = !ctl0_q.valid || dist_ready;

  always_comb begin
    ctl0_d.valid = s_axis_tvalid_i;
    ctl0_d.ok    = s_axis_tuser_i;
    ctl0_d.last  = s_axis_tlast_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (s_axis_tready_o) begin
      ctl0_q <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      x0_q <= s_axis_tdata_i[COORD_WIDTH-1:0];
      y0_q <= s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH];
    end
  end

  npib_dist #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ctl_i   (ctl0_q),
    .in_x_i     (x0_q),
    .in_y_i     (y0_q),
    .in_ready_o (dist_ready),
    .box_min_x_i(min_x_q),
    .box_max_x_i(max_x_q),
    .box_min_y_i(min_y_q),
    .box_max_y_i(max_y_q),
    .out_ctl_o  (dist_ctl),
    .out_x_o    (dist_x),
    .out_y_o    (dist_y),
    .out_dist_o (dist_d),
    .out_ready_i(best_ready)
  );

  npib_best #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_best (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ctl_i     (dist_ctl),
    .in_x_i       (dist_x),
    .in_y_i       (dist_y),
    .in_dist_i    (dist_d),
    .in_ready_o   (best_ready),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_lateral_o(res_lat),
    .res_forward_o(res_fwd)
  );

  assign m_axis_tdata_o = TDATA_W'({res_fwd, res_lat});

endmodule

`default_nettype wire

/* design/npib_checker.sv */
// Port-level checks for the nearest in-box point finder, bound to the top.
`default_nettype none

module npib_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                s_axis_tvalid_i,
  input wire                                s_axis_tready_o,
  input wire [((2*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata_i,
  input wire                                s_axis_tuser_i,
  input wire                                s_axis_tlast_i,
  input wire                                m_axis_tvalid_o,
  input wire                                m_axis_tready_i,
  input wire [((2*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata_o,
  input wire                                cfg_we_i,
  input wire [npib_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input wire [COORD_WIDTH-1:0]              cfg_wdata_i
);
  import npib_pkg::*;

  localparam int PEND_W = 16;

  logic signed [COORD_WIDTH-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [COORD_WIDTH-1:0] lat, fwd;
  logic [PEND_W-1:0]             pend_q;
  logic                          sat_q;
  logic                          last_in, beat_out;

  assign lat      = m_axis_tdata_o[COORD_WIDTH-1:0];
  assign fwd      = m_axis_tdata_o[2*COORD_WIDTH-1:COORD_WIDTH];
  assign last_in  = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign beat_out = m_axis_tvalid_o && m_axis_tready_i;

  // Shadow of the box bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= COORD_WIDTH'(BOX_MIN_X_RST);
      max_x_q <= COORD_WIDTH'(BOX_MAX_X_RST);
      min_y_q <= COORD_WIDTH'(BOX_MIN_Y_RST);
      max_y_q <= COORD_WIDTH'(BOX_MAX_Y_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_BOX_MIN_X: min_x_q <= cfg_wdata_i;
        CFG_BOX_MAX_X: max_x_q <= cfg_wdata_i;
        CFG_BOX_MIN_Y: min_y_q <= cfg_wdata_i;
        CFG_BOX_MAX_Y: max_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Last beats in minus result beats out; stops tracking once saturated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      sat_q  <= 1'b0;
    end else if (!sat_q) begin
      if (last_in && !beat_out) begin
        if (pend_q == {PEND_W{1'b1}}) sat_q <= 1'b1;
        else pend_q <= pend_q + PEND_W'(1);
      end else if (beat_out && !last_in && pend_q != '0) begin
        pend_q <= pend_q - PEND_W'(1);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_out_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (fwd >= min_x_q) && (fwd <= max_x_q) &&
                        (lat >= min_y_q) && (lat <= max_y_q))
    else $error("result lies outside the box");

  a_out_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> sat_q || (pend_q != '0))
    else $error("result without a preceding last point");

  a_idle_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid coming out of reset");

endmodule

bind nearest_point_in_box npib_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_npib_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .s_axis_tuser_i (s_axis_tuser_i),
  .s_axis_tlast_i (s_axis_tlast_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .cfg_we_i       (cfg_we_i),
  .cfg_addr_i     (cfg_addr_i),
  .cfg_wdata_i    (cfg_wdata_i)
);

`default_nettype wire
